/* rtl/hci_pkg.sv */
// ----------------------------------------------------------------------------
// hci_pkg: shared types and constants of the Hermite curve interpolator
// Field widths, command and status codes, and the queue item format.
// ----------------------------------------------------------------------------
package hci_pkg;

   localparam int MAX_KNOTS_DEF = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam int CMD_W = 1;
   localparam int IDX_W = 5;
   localparam int ABS_W = 31;
   localparam int VAL_W = 48;
   localparam int QRY_W = 32;
   localparam int CNT_W = 6;
   localparam int STS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } command_type;

   typedef logic [STS_W-1:0] status_type;

   localparam status_type STATUS_INTERP = 2'd0;
   localparam status_type STATUS_EXTRAP = 2'd1;
   localparam status_type STATUS_ZERO   = 2'd2;

   // Classified item as it sits in the queue between front and back.
   typedef struct packed {
      logic                    is_eval;
      logic [IDX_W-1:0]        knot_index;
      logic [ABS_W-1:0]        abscissa;
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] slope;
      logic [QRY_W-1:0]        magnitude;
      logic                    mag_zero;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

/* rtl/hci_ram.sv */
// ----------------------------------------------------------------------------
// hci_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/hci_front.sv */
// ----------------------------------------------------------------------------
// hci_front: input side of the interpolator
// Accept items, take the query magnitude, and hold them in a short queue.
// ----------------------------------------------------------------------------
module hci_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [hci_pkg::CMD_W-1:0]          req_command,
   input  logic [hci_pkg::IDX_W-1:0]          req_knot_index,
   input  logic [hci_pkg::ABS_W-1:0]          req_knot_abscissa,
   input  logic signed [hci_pkg::VAL_W-1:0]   req_knot_value,
   input  logic signed [hci_pkg::VAL_W-1:0]   req_knot_slope,
   input  logic signed [hci_pkg::QRY_W-1:0]   req_query_point,
   input  logic                               head_pop,
   output hci_pkg::head_type                  head
);
   import hci_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   item_type         item_in;
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QCW-1:0]   count_ff;
   logic             accept;
   logic             take;

   // classify: command decode and absolute value of the query
   always_comb begin
      item_in.is_eval    = (req_command == CMD_EVAL);
      item_in.knot_index = req_knot_index;
      item_in.abscissa   = req_knot_abscissa;
      item_in.value      = req_knot_value;
      item_in.slope      = req_knot_slope;
      item_in.magnitude  = req_query_point[QRY_W-1] ? (~req_query_point + 1'b1)
                                                    : req_query_point;
      item_in.mag_zero   = (req_query_point == '0);
   end

   assign full   = (count_ff == QCW'(QUEUE_DEPTH));
   assign accept = push & ~full;
   assign take   = head_pop & head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({accept, take})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

/* rtl/hci_div.sv */
// ----------------------------------------------------------------------------
// hci_div: restoring divider for the segment position
// Quotient = (num << 30) / den for num <= den, one bit per cycle.
// ----------------------------------------------------------------------------
module hci_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [hci_pkg::ABS_W-1:0] num,
   input  logic [hci_pkg::ABS_W-1:0] den,
   output logic                      done,
   output logic [hci_pkg::ABS_W-1:0] quot
);
   import hci_pkg::*;

   localparam int CW = $clog2(ABS_W + 1);

   logic [ABS_W:0]   rem_ff;
   logic [ABS_W-1:0] den_ff;
   logic [ABS_W-1:0] quot_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             ge;
   logic [ABS_W:0]   diff;

   assign ge   = (rem_ff >= {1'b0, den_ff});
   assign diff = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(ABS_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff  <= {1'b0, num};
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= {diff[ABS_W-1:0], 1'b0};
         quot_ff <= {quot_ff[ABS_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/hci_mul.sv */
// ----------------------------------------------------------------------------
// hci_mul: pipelined sign-magnitude multiply with truncating shift
// Result = trunc(s*m/2^k), k is 30 or 24, through a chain of registered stages.
// ----------------------------------------------------------------------------
module hci_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [47:0] s,
   input  logic signed [32:0] m,
   input  logic               k30,
   output logic               done,
   output logic signed [57:0] prod
);

   logic [47:0]        as_ff;
   logic [32:0]        am_ff;
   logic               neg_ff;
   logic               k30_ff;
   logic [64:0]        plo_ff;
   logic [63:0]        phi_ff;
   logic [80:0]        full_ff;
   logic signed [57:0] prod_ff;
   logic [4:0]         vld_ff;
   logic [56:0]        mag;

   assign mag = k30_ff ? 57'(full_ff >> 30) : 57'(full_ff >> 24);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], go};
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         as_ff  <= s[47] ? 48'(-s) : 48'(s);
         am_ff  <= m[32] ? 33'(-m) : 33'(m);
         neg_ff <= s[47] ^ m[32];
         k30_ff <= k30;
      end
      plo_ff  <= as_ff * am_ff[16:0];
      phi_ff  <= as_ff * am_ff[32:17];
      full_ff <= {phi_ff, 17'b0} + {16'b0, plo_ff};
      prod_ff <= neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign done = vld_ff[4];
   assign prod = prod_ff;

endmodule

/* rtl/hci_back.sv */
// ----------------------------------------------------------------------------
// hci_back: execution side of the interpolator
// Store knots, search the segment, run the Hermite sequence, hold the result.
// ----------------------------------------------------------------------------
module hci_back #(
   parameter int MAX_KNOTS = hci_pkg::MAX_KNOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hci_pkg::head_type                head,
   output logic                             head_pop,
   input  logic [hci_pkg::CNT_W-1:0]        point_count,
   input  logic                             pop,
   output logic                             empty,
   output logic signed [hci_pkg::VAL_W-1:0] rsp_curve_value,
   output logic [hci_pkg::STS_W-1:0]        rsp_eval_status
);
   import hci_pkg::*;

   localparam int AW = $clog2(MAX_KNOTS);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LAST = 7'b0000010,
      S_SCAN = 7'b0000100,
      S_SEG0 = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_MUL  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   localparam logic [3:0] STEP_Z2  = 4'd0;
   localparam logic [3:0] STEP_Z3  = 4'd1;
   localparam logic [3:0] STEP_W10 = 4'd2;
   localparam logic [3:0] STEP_W11 = 4'd3;
   localparam logic [3:0] STEP_T00 = 4'd4;
   localparam logic [3:0] STEP_T01 = 4'd5;
   localparam logic [3:0] STEP_T10 = 4'd6;
   localparam logic [3:0] STEP_T11 = 4'd7;
   localparam logic [3:0] STEP_EXT = 4'd8;

   state_type               state_ff;
   logic [3:0]              step_ff;
   logic [AW-1:0]           ptr_ff;
   logic [AW-1:0]           n_m1_ff;
   logic [QRY_W-1:0]        b_ff;
   logic [ABS_W-1:0]        prev_ff;
   logic [ABS_W-1:0]        a1_ff;
   logic [ABS_W-1:0]        l_ff;
   logic signed [VAL_W-1:0] v0_ff;
   logic signed [VAL_W-1:0] v1_ff;
   logic signed [VAL_W-1:0] s0_ff;
   logic signed [VAL_W-1:0] s1_ff;
   logic [30:0]             z_ff;
   logic [30:0]             z2_ff;
   logic [30:0]             z3_ff;
   logic signed [32:0]      w10_ff;
   logic signed [32:0]      w11_ff;
   logic signed [59:0]      acc_ff;
   status_type              status_ff;
   logic                    mul_go_ff;
   logic                    div_go_ff;
   logic                    out_valid_ff;
   logic signed [VAL_W-1:0] out_value_ff;
   status_type              out_status_ff;

   item_type                hd;
   logic [31:0]             n_eff;
   logic                    idx_ok;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [ABS_W-1:0]        rd_absc;
   logic [VAL_W-1:0]        rd_val;
   logic [VAL_W-1:0]        rd_slp;
   logic                    in_seg;
   logic                    beyond;
   logic [ABS_W-1:0]        seg_len;
   logic [ABS_W-1:0]        span;
   logic signed [34:0]      z_s;
   logic signed [34:0]      z2_s;
   logic signed [34:0]      z3_s;
   logic signed [34:0]      h00;
   logic signed [34:0]      h01;
   logic signed [34:0]      h10;
   logic signed [34:0]      h11;
   logic signed [47:0]      mul_s;
   logic signed [32:0]      mul_m;
   logic                    mul_k30;
   logic                    mul_done;
   logic signed [57:0]      mul_p;
   logic                    div_done;
   logic [ABS_W-1:0]        div_q;
   logic signed [VAL_W-1:0] sat_value;
   logic                    pop_ok;

   assign hd      = head.item;
   assign n_eff   = (32'(point_count) > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : 32'(point_count);
   assign idx_ok  = (32'(hd.knot_index) < 32'(MAX_KNOTS));
   assign wr_addr = AW'(hd.knot_index);
   assign in_seg  = ({1'b0, prev_ff} <= b_ff) && (b_ff <= {1'b0, rd_absc});
   assign beyond  = (b_ff > {1'b0, rd_absc});
   assign seg_len = a1_ff - prev_ff;
   assign span    = b_ff[ABS_W-1:0] - prev_ff;
   assign pop_ok  = pop & out_valid_ff;

   // table access: writes come from the queue head, reads follow the sequencer
   always_comb begin
      head_pop = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = ptr_ff;
      unique case (state_ff)
         S_IDLE: begin
            head_pop = head.valid;
            wr_en    = head.valid & ~hd.is_eval & idx_ok;
            rd_addr  = AW'(n_eff - 32'd1);
         end
         S_LAST: rd_addr = '0;
         S_SCAN: rd_addr = ((ptr_ff != '0) && in_seg) ? ptr_ff - 1'b1 : ptr_ff + 1'b1;
         default: rd_addr = ptr_ff;
      endcase
   end

   hci_ram #(.WIDTH(ABS_W), .DEPTH(MAX_KNOTS)) u_absc_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(hd.abscissa),
      .rd_addr(rd_addr), .rd_data(rd_absc)
   );

   hci_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KNOTS)) u_val_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(hd.value),
      .rd_addr(rd_addr), .rd_data(rd_val)
   );

   hci_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KNOTS)) u_slp_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(hd.slope),
      .rd_addr(rd_addr), .rd_data(rd_slp)
   );

   // Hermite basis in Q2.30
   assign z_s  = $signed({4'b0, z_ff});
   assign z2_s = $signed({4'b0, z2_ff});
   assign z3_s = $signed({4'b0, z3_ff});
   assign h00  = (35'sd1 <<< 30) - 35'sd3 * z2_s + 35'sd2 * z3_s;
   assign h01  = 35'sd3 * z2_s - 35'sd2 * z3_s;
   assign h10  = z_s - 35'sd2 * z2_s + z3_s;
   assign h11  = z3_s - z2_s;

   always_comb begin
      mul_k30 = 1'b1;
      case (step_ff)
         STEP_Z2: begin
            mul_s = $signed({17'b0, z_ff});
            mul_m = $signed({2'b0, z_ff});
         end
         STEP_Z3: begin
            mul_s = $signed({17'b0, z2_ff});
            mul_m = $signed({2'b0, z_ff});
         end
         STEP_W10: begin
            mul_s = {{13{h10[34]}}, h10};
            mul_m = $signed({2'b0, l_ff});
         end
         STEP_W11: begin
            mul_s = {{13{h11[34]}}, h11};
            mul_m = $signed({2'b0, l_ff});
         end
         STEP_T00: begin
            mul_s = v0_ff;
            mul_m = h00[32:0];
         end
         STEP_T01: begin
            mul_s = v1_ff;
            mul_m = h01[32:0];
         end
         STEP_T10: begin
            mul_s   = s0_ff;
            mul_m   = w10_ff;
            mul_k30 = 1'b0;
         end
         STEP_T11: begin
            mul_s   = s1_ff;
            mul_m   = w11_ff;
            mul_k30 = 1'b0;
         end
         default: begin
            mul_s   = s1_ff;
            mul_m   = $signed({1'b0, b_ff} - {2'b0, a1_ff});
            mul_k30 = 1'b0;
         end
      endcase
   end

   hci_mul u_mul (
      .clock(clock), .reset(reset), .go(mul_go_ff), .s(mul_s), .m(mul_m),
      .k30(mul_k30), .done(mul_done), .prod(mul_p)
   );

   hci_div u_div (
      .clock(clock), .reset(reset), .go(div_go_ff), .num(span), .den(l_ff),
      .done(div_done), .quot(div_q)
   );

   // saturate to the 48-bit result range
   always_comb begin
      if (acc_ff[59:47] == {13{acc_ff[59]}}) begin
         sat_value = acc_ff[VAL_W-1:0];
      end else begin
         sat_value = acc_ff[59] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         if (pop_ok) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head.valid && hd.is_eval) begin
                  b_ff    <= hd.magnitude;
                  n_m1_ff <= AW'(n_eff - 32'd1);
                  if ((n_eff == 32'd0) || hd.mag_zero) begin
                     acc_ff    <= '0;
                     status_ff <= STATUS_ZERO;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_LAST;
                  end
               end
            end
            S_LAST: begin
               if (beyond) begin
                  a1_ff     <= rd_absc;
                  s1_ff     <= $signed(rd_slp);
                  acc_ff    <= {{12{rd_val[VAL_W-1]}}, rd_val};
                  status_ff <= STATUS_EXTRAP;
                  step_ff   <= STEP_EXT;
                  mul_go_ff <= 1'b1;
                  state_ff  <= S_MUL;
               end else if (n_m1_ff == '0) begin
                  acc_ff    <= '0;
                  status_ff <= STATUS_ZERO;
                  state_ff  <= S_DONE;
               end else begin
                  ptr_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if ((ptr_ff != '0) && in_seg) begin
                  a1_ff    <= rd_absc;
                  v1_ff    <= $signed(rd_val);
                  s1_ff    <= $signed(rd_slp);
                  state_ff <= S_SEG0;
               end else if (ptr_ff == n_m1_ff) begin
                  acc_ff    <= '0;
                  status_ff <= STATUS_ZERO;
                  state_ff  <= S_DONE;
               end else begin
                  prev_ff <= rd_absc;
                  ptr_ff  <= ptr_ff + 1'b1;
               end
            end
            S_SEG0: begin
               v0_ff     <= $signed(rd_val);
               s0_ff     <= $signed(rd_slp);
               l_ff      <= seg_len;
               status_ff <= STATUS_INTERP;
               if (seg_len == '0) begin
                  acc_ff   <= {{12{rd_val[VAL_W-1]}}, rd_val};
                  state_ff <= S_DONE;
               end else begin
                  acc_ff    <= '0;
                  div_go_ff <= 1'b1;
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  z_ff      <= div_q;
                  step_ff   <= STEP_Z2;
                  mul_go_ff <= 1'b1;
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  case (step_ff)
                     STEP_Z2:  z2_ff  <= mul_p[30:0];
                     STEP_Z3:  z3_ff  <= mul_p[30:0];
                     STEP_W10: w10_ff <= mul_p[32:0];
                     STEP_W11: w11_ff <= mul_p[32:0];
                     default:  acc_ff <= acc_ff + {{2{mul_p[57]}}, mul_p};
                  endcase
                  if ((step_ff == STEP_T11) || (step_ff == STEP_EXT)) begin
                     state_ff <= S_DONE;
                  end else begin
                     step_ff   <= step_ff + 1'b1;
                     mul_go_ff <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (!out_valid_ff || pop_ok) begin
                  out_valid_ff  <= 1'b1;
                  out_value_ff  <= sat_value;
                  out_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign empty           = ~out_valid_ff;
   assign rsp_curve_value = out_value_ff;
   assign rsp_eval_status = out_status_ff;

endmodule

/* rtl/hermite_curve_interpolator_top.sv */
// ----------------------------------------------------------------------------
// hermite_curve_interpolator_top: cubic Hermite curve evaluation over a knot table
// Write commands fill the knot table; evaluate commands return one curve value.
// ----------------------------------------------------------------------------
//
//   channel  handshake         payload
//   req      push / full       command, knot index/abscissa/value/slope, query
//   rsp      empty / pop       curve_value, eval_status
//   csr      csr_wr_en         csr_wr_data = point_count
//
// A knot write leaves the queue whenever the sequencer is idle. An evaluation
// answers zero at once, extrapolates past the last knot with one product, or
// interpolates on the segment that holds the query: the segment search reads
// one knot per cycle from the table RAMs, the divider makes one quotient bit
// per cycle and the eight products share one pipelined multiplier.
// Reset is synchronous and clears the queue, sequencer and output register;
// the knot tables are not cleared. The two-entry queue keeps accepting items
// while the back end works, and a finished result waits in the output
// register without blocking table writes behind it.
//
module hermite_curve_interpolator_top #(
   parameter int MAX_KNOTS = hci_pkg::MAX_KNOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item input
   input  logic                             push,
   output logic                             full,
   input  logic [hci_pkg::CMD_W-1:0]        req_command,
   input  logic [hci_pkg::IDX_W-1:0]        req_knot_index,
   input  logic [hci_pkg::ABS_W-1:0]        req_knot_abscissa,
   input  logic signed [hci_pkg::VAL_W-1:0] req_knot_value,
   input  logic signed [hci_pkg::VAL_W-1:0] req_knot_slope,
   input  logic signed [hci_pkg::QRY_W-1:0] req_query_point,
   // result output
   output logic                             empty,
   input  logic                             pop,
   output logic signed [hci_pkg::VAL_W-1:0] rsp_curve_value,
   output logic [hci_pkg::STS_W-1:0]        rsp_eval_status,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [hci_pkg::CNT_W-1:0]        csr_wr_data
);
   import hci_pkg::*;

   logic [CNT_W-1:0] point_count_ff;
   head_type         head;
   logic             head_pop;

   // knot count register; write it only while the block is idle, the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   // front: accept, classify and queue items
   hci_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_knot_index    (req_knot_index),
      .req_knot_abscissa (req_knot_abscissa),
      .req_knot_value    (req_knot_value),
      .req_knot_slope    (req_knot_slope),
      .req_query_point   (req_query_point),
      .head_pop          (head_pop),
      .head              (head)
   );

   // back: table storage, segment search and Hermite arithmetic
   hci_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_pop        (head_pop),
      .point_count     (point_count_ff),
      .pop             (pop),
      .empty           (empty),
      .rsp_curve_value (rsp_curve_value),
      .rsp_eval_status (rsp_eval_status)
   );

endmodule

/* rtl/hci_checker.sv */
// ----------------------------------------------------------------------------
// hci_checker: port-level assertions for the Hermite curve interpolator
// Watch reset behavior, result stability and status encoding.
// ----------------------------------------------------------------------------
module hci_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             full,
   input logic                             empty,
   input logic                             pop,
   input logic signed [hci_pkg::VAL_W-1:0] rsp_curve_value,
   input logic [hci_pkg::STS_W-1:0]        rsp_eval_status
);
   import hci_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input queue full after reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_curve_value) && $stable(rsp_eval_status)))
      else $error("waiting item changed");

   a_zero_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_eval_status == STATUS_ZERO)) |-> (rsp_curve_value == '0))
      else $error("zero status with nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_eval_status == STATUS_INTERP || rsp_eval_status == STATUS_EXTRAP
                  || rsp_eval_status == STATUS_ZERO))
      else $error("status code out of range");

endmodule

bind hermite_curve_interpolator_top hci_checker u_hci_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_curve_value (rsp_curve_value),
   .rsp_eval_status (rsp_eval_status)
);

/* verif/tb_hermite_curve_interpolator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hermite_curve_interpolator_top: self-checking bench for the curve block
// Fills the knot table, evaluates queries across all segments and beyond,
// and compares every curve value and status with an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_hermite_curve_interpolator_top;
   import hci_pkg::*;

   localparam int NKNOT = 32;
   localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct {
      command_type             cmd;
      logic [IDX_W-1:0]        idx;
      logic [ABS_W-1:0]        absc;
      logic signed [VAL_W-1:0] val;
      logic signed [VAL_W-1:0] slp;
      logic signed [QRY_W-1:0] qry;
   } req_item_type;

   typedef struct {
      logic signed [VAL_W-1:0] curve;
      status_type              status;
   } curve_result_type;

   logic clock = 0;
   logic reset = 1;
   logic push = 0, pop = 0, csr_wr_en = 0;
   logic full, empty;
   logic [CMD_W-1:0]        req_command = '0;
   logic [IDX_W-1:0]        req_knot_index = '0;
   logic [ABS_W-1:0]        req_knot_abscissa = '0;
   logic signed [VAL_W-1:0] req_knot_value = '0;
   logic signed [VAL_W-1:0] req_knot_slope = '0;
   logic signed [QRY_W-1:0] req_query_point = '0;
   logic [CNT_W-1:0]        csr_wr_data = '0;
   logic signed [VAL_W-1:0] rsp_curve_value;
   logic [STS_W-1:0]        rsp_eval_status;

   // Prediction state: knot tables and the live knot count.
   longint unsigned knot_x [NKNOT];
   longint          knot_y [NKNOT];
   longint          knot_dy[NKNOT];
   int              live_count = 0;

   req_item_type     pending_items[$];
   curve_result_type expected_curve[$];
   int               fail_count = 0;
   bit               quiet = 0;  // no idling in this stretch

   hermite_curve_interpolator_top dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_command(req_command), .req_knot_index(req_knot_index),
      .req_knot_abscissa(req_knot_abscissa), .req_knot_value(req_knot_value),
      .req_knot_slope(req_knot_slope), .req_query_point(req_query_point),
      .empty(empty), .pop(pop),
      .rsp_curve_value(rsp_curve_value), .rsp_eval_status(rsp_eval_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Truncated product s*m/2^k in sign-magnitude; the magnitude fits in 128 bits.
   function automatic longint scaled_product(longint s, longint m, int k);
      logic [127:0] mag;
      bit           neg;
      neg = (s < 0) != (m < 0);
      mag = 128'(s < 0 ? -s : s) * 128'(m < 0 ? -m : m);
      mag = mag >> k;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic longint clamp48(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Apply one item to the prediction state, queue its result if it has one.
   function automatic void predict_curve(req_item_type it);
      longint unsigned b, span, a0, a1;
      longint z, z2, z3, h00, h01, h10, h11, sum;
      curve_result_type r;
      int n;
      if (it.cmd == CMD_WRITE) begin
         knot_x[it.idx] = it.absc;
         knot_y[it.idx] = it.val;
         knot_dy[it.idx] = it.slp;
         return;
      end
      r.curve = '0;
      r.status = STATUS_ZERO;
      b = it.qry[31] ? longint'(33'h1_0000_0000 - {1'b0, it.qry}) : it.qry;
      n = live_count > NKNOT ? NKNOT : live_count;
      if (n != 0 && b != 0) begin
         if (b > knot_x[n-1]) begin
            r.curve = VAL_W'(clamp48(knot_y[n-1] +
                                     scaled_product(knot_dy[n-1], b - knot_x[n-1], 24)));
            r.status = STATUS_EXTRAP;
         end else begin
            for (int i = 0; i + 1 < n; i++) begin
               a0 = knot_x[i];
               a1 = knot_x[i+1];
               if (b >= a0 && b <= a1) begin
                  span = a1 - a0;
                  r.status = STATUS_INTERP;
                  if (span == 0) r.curve = VAL_W'(knot_y[i]);
                  else begin
                     z   = ((b - a0) << 30) / span;
                     z2  = (z * z) >>> 30;
                     z3  = (z2 * z) >>> 30;
                     h00 = (64'sd1 << 30) - 3 * z2 + 2 * z3;
                     h01 = 3 * z2 - 2 * z3;
                     h10 = z - 2 * z2 + z3;
                     h11 = z3 - z2;
                     sum = scaled_product(knot_y[i], h00, 30)
                         + scaled_product(knot_y[i+1], h01, 30)
                         + scaled_product(knot_dy[i], scaled_product(h10, span, 30), 24)
                         + scaled_product(knot_dy[i+1], scaled_product(h11, span, 30), 24);
                     r.curve = VAL_W'(clamp48(sum));
                  end
                  break;
               end
            end
         end
      end
      expected_curve.push_back(r);
   endfunction

   function automatic longint rand48();
      return longint'({$urandom, $urandom}) <<< 16 >>> 16;
   endfunction

   // Knot values: mostly moderate, sometimes full range so saturation shows up.
   function automatic longint rand_val();
      if ($urandom_range(9) == 0) return rand48();
      return longint'($signed($urandom)) <<< $urandom_range(14);
   endfunction

   function automatic req_item_type knot_write(int idx, longint unsigned x, longint y,
                                               longint dy);
      req_item_type it;
      it.cmd = CMD_WRITE; it.idx = IDX_W'(idx); it.absc = ABS_W'(x);
      it.val = VAL_W'(y); it.slp = VAL_W'(dy);
      it.qry = $urandom;  // don't-care bits still toggle
      return it;
   endfunction

   function automatic req_item_type eval_at(logic [31:0] q);
      req_item_type it;
      it.cmd = CMD_EVAL; it.idx = IDX_W'($urandom); it.absc = ABS_W'($urandom);
      it.val = rand48(); it.slp = rand48(); it.qry = q;
      return it;
   endfunction

   // Random query: inside the knot span, at a knot, past the end, or raw.
   function automatic logic [31:0] rand_query(int n);
      logic [31:0] m;
      int k;
      k = n > 0 ? $urandom_range(n - 1) : 0;
      case ($urandom_range(9))
         0:       m = $urandom;
         1:       m = 32'(knot_x[k]);
         2:       m = 32'(knot_x[n > 0 ? n - 1 : 0] + $urandom_range(1, 1 << 20));
         default: m = $urandom_range(32'(knot_x[n > 0 ? n - 1 : 0]));
      endcase
      if ($urandom_range(1)) m = -m;
      return m;
   endfunction

   // Driver: present the queue head, advance on acceptance.
   always @(posedge clock) begin
      if (reset) push <= 0;
      else begin
         if (push && !full) begin
            predict_curve(pending_items.pop_front());
         end
         if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 11)) begin
            push <= 1;
            req_command <= pending_items[0].cmd;
            req_knot_index <= pending_items[0].idx;
            req_knot_abscissa <= pending_items[0].absc;
            req_knot_value <= pending_items[0].val;
            req_knot_slope <= pending_items[0].slp;
            req_query_point <= pending_items[0].qry;
         end else push <= 0;
      end
   end

   // Monitor: check each popped result against the oldest prediction.
   always @(posedge clock) begin
      curve_result_type e;
      if (reset) pop <= 0;
      else begin
         if (pop && !empty) begin
            if (expected_curve.size() == 0) begin
               $error("result with no evaluation pending");
               fail_count++;
            end else begin
               e = expected_curve.pop_front();
               if (rsp_curve_value !== e.curve) begin
                  $error("curve_value expected %0d got %0d", e.curve, rsp_curve_value);
                  fail_count++;
               end
               if (rsp_eval_status !== e.status) begin
                  $error("eval_status expected %0d got %0d", e.status, rsp_eval_status);
                  fail_count++;
               end
            end
         end
         pop <= quiet || $urandom_range(99) >= 11;
      end
   end

   task automatic drain();
      while (pending_items.size() != 0 || push || expected_curve.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_count(int n);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= CNT_W'(n);
      live_count = n;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // Fill the table with increasing abscissas; sometimes a repeated
   // abscissa for a zero-length segment. Step sizes set by 'step_max'.
   task automatic load_knots(int n, longint unsigned step_max, bit allow_dup);
      longint unsigned x;
      x = $urandom_range(1 << 20);
      for (int i = 0; i < n; i++) begin
         pending_items.push_back(knot_write(i, x, rand_val(), rand_val()));
         if (!(allow_dup && $urandom_range(7) == 0))
            x += $urandom_range(1, 32'(step_max));
      end
   endtask

   initial begin
      int n;
      longint unsigned step;
      repeat (9) @(posedge clock);
      reset <= 0;

      // Directed: empty curve, extremes, zero-length segment, top abscissa.
      set_count(0);
      pending_items.push_back(eval_at(32'h4000_0000));
      pending_items.push_back(knot_write(0, 0, SAT_HI, SAT_HI));
      pending_items.push_back(knot_write(1, 31'h0100_0000, SAT_LO, SAT_LO));
      pending_items.push_back(knot_write(2, 31'h0100_0000, 48'sd65536, -48'sd65536));
      pending_items.push_back(knot_write(3, 31'h7FFF_FFFF, -48'sd5, 48'sd3 << 40));
      for (int i = 4; i < NKNOT; i++)
         pending_items.push_back(knot_write(i, 31'h7FFF_FFFF, rand48(), rand48()));
      drain();
      set_count(4);
      pending_items.push_back(eval_at(32'h0));
      pending_items.push_back(eval_at(32'h0080_0000));
      pending_items.push_back(eval_at(32'hFF80_0000));
      pending_items.push_back(eval_at(32'h0100_0000));
      pending_items.push_back(eval_at(32'h4000_0000));
      pending_items.push_back(eval_at(32'h7FFF_FFFF));
      pending_items.push_back(eval_at(32'h8000_0000));
      pending_items.push_back(eval_at(32'h0000_0001));
      drain();
      set_count(63);  // above the table size, acts as full table
      pending_items.push_back(eval_at(32'h8000_0000));
      pending_items.push_back(eval_at(32'hC000_0000));
      pending_items.push_back(eval_at(32'h7FFF_FFFF));
      drain();

      // Random phases: reload, pick a count, then mostly evaluations.
      for (int ph = 0; ph < 16; ph++) begin
         quiet = (ph == 5 || ph == 6);
         n = (ph % 4 == 0) ? NKNOT : $urandom_range(1, NKNOT);
         step = (ph % 3 == 0) ? 64'h0300_0000 : 64'h0010_0000;
         load_knots(NKNOT, step, ph % 2);
         // invalid slot writes cannot occur with 5-bit index; mix rewrites in
         drain();
         case (ph)
            3:       set_count(0);
            7:       set_count(33);
            default: set_count(n);
         endcase
         for (int k = 0; k < 40; k++) begin
            if ($urandom_range(19) == 0) begin
               int i;
               i = $urandom_range(NKNOT - 1);
               pending_items.push_back(knot_write(i, knot_x[i], rand_val(), rand_val()));
            end else
               pending_items.push_back(eval_at(rand_query(live_count > NKNOT ? NKNOT
                                                                     : live_count)));
         end
         drain();
      end
      quiet = 0;

      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
